FILE: rtl/ethernet_tx_framer_crc32_assert.svh
// ----------------------------------------------------------------------------
// Ethernet TX framer assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_TX_FRAMER_CRC32_ASSERT_SVH
`define ETHERNET_TX_FRAMER_CRC32_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ETF_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("etf assertion failed: same-cycle implication");
// next-cycle implication
`define ETF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("etf assertion failed: next-cycle implication");
`else
`define ETF_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ETF_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: rtl/etf_pkg.sv
// ----------------------------------------------------------------------------
// Ethernet TX framer package
// Shared types, constants and the byte-wise CRC-32 update.
// ----------------------------------------------------------------------------
package etf_pkg;

    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 2;
    localparam int HDR_BYTES = 14;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // one accepted payload transfer
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [15:0] ethertype;
        logic [7:0]  payload_byte;
        logic        first_byte;
        logic        last_byte;
    } item_t;

    // one frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } out_t;

    // write side of the output queue
    typedef struct packed {
        logic push;
        out_t data;
    } oq_wr_t;

    // sequencer status
    typedef struct packed {
        logic at_start;
    } back_stat_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/etf_front.sv
// ----------------------------------------------------------------------------
// Ethernet TX framer front end
// Accepts payload transfers into a short first-word-fall-through queue.
// ----------------------------------------------------------------------------
module etf_front #(
    parameter int DEPTH = etf_pkg::IN_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  etf_pkg::item_t item,
    output logic          full,
    output etf_pkg::item_t head,
    output logic          head_valid,
    input  logic          pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    etf_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

FILE: rtl/etf_back.sv
// ----------------------------------------------------------------------------
// Ethernet TX framer back end
// Expands queued items into frame bytes: header before a first byte, payload, padding and FCS after a last byte.
// ----------------------------------------------------------------------------
module etf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  etf_pkg::item_t      head,
    input  logic                head_valid,
    output logic                item_pop,
    input  logic [47:0]         source_mac,
    input  logic                oq_ready,
    output etf_pkg::oq_wr_t     oq_wr,
    output etf_pkg::back_stat_t stat
);

    typedef enum logic [4:0] {
        ST_START = 5'b00001,
        ST_HDR   = 5'b00010,
        ST_BODY  = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_FCS   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] crc_reg, crc_next;
    logic [1:0]  mod4_reg, mod4_next;

    logic [8*etf_pkg::HDR_BYTES-1:0] hdr_vec;
    logic [7:0]  hdr_bytes [etf_pkg::HDR_BYTES];
    logic        fire;
    logic        do_body;
    logic [1:0]  mod4_inc;
    logic [1:0]  pad;
    logic [31:0] fcs;

    // header bytes in send order
    assign hdr_vec = {head.dest_mac, source_mac, head.ethertype};
    always_comb
    begin
        for (int i = 0; i < etf_pkg::HDR_BYTES; i++)
        begin
            hdr_bytes[i] = hdr_vec[8*(etf_pkg::HDR_BYTES-1-i) +: 8];
        end
    end

    assign fire     = head_valid && oq_ready;
    assign mod4_inc = mod4_reg + 2'd1;
    assign pad      = 2'd0 - mod4_inc;
    assign fcs      = ~crc_reg;
    assign stat.at_start = (state_reg == ST_START);

    // sequencer: one frame byte per transfer into the output queue
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        mod4_next  = mod4_reg;
        item_pop   = 1'b0;
        oq_wr      = '0;
        do_body    = 1'b0;

        unique case (state_reg)
            ST_START:
            begin
                if (fire)
                begin
                    if (head.first_byte)
                    begin
                        oq_wr.push            = 1'b1;
                        oq_wr.data.frame_byte = hdr_bytes[0];
                        crc_next   = etf_pkg::crc_byte(etf_pkg::CRC_INIT, hdr_bytes[0]);
                        mod4_next  = 2'd0;
                        cnt_next   = 4'd1;
                        state_next = ST_HDR;
                    end
                    else
                    begin
                        do_body = 1'b1;
                    end
                end
            end
            ST_HDR:
            begin
                if (fire)
                begin
                    oq_wr.push            = 1'b1;
                    oq_wr.data.frame_byte = hdr_bytes[cnt_reg];
                    crc_next = etf_pkg::crc_byte(crc_reg, hdr_bytes[cnt_reg]);
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'(etf_pkg::HDR_BYTES - 1))
                    begin
                        state_next = ST_BODY;
                    end
                end
            end
            ST_BODY:
            begin
                do_body = fire;
            end
            ST_PAD:
            begin
                if (fire)
                begin
                    oq_wr.push = 1'b1;
                    if (cnt_reg == 4'd1)
                    begin
                        cnt_next   = 4'd0;
                        state_next = ST_FCS;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 4'd1;
                    end
                end
            end
            ST_FCS:
            begin
                if (fire)
                begin
                    oq_wr.push            = 1'b1;
                    oq_wr.data.frame_byte = fcs[{cnt_reg[1:0], 3'b000} +: 8];
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        oq_wr.data.frame_end = 1'b1;
                        item_pop   = 1'b1;
                        crc_next   = etf_pkg::CRC_INIT;
                        mod4_next  = 2'd0;
                        cnt_next   = 4'd0;
                        state_next = ST_START;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_START;
            end
        endcase

        // payload byte, then tail or next item
        if (do_body)
        begin
            oq_wr.push            = 1'b1;
            oq_wr.data.frame_byte = head.payload_byte;
            crc_next  = etf_pkg::crc_byte(crc_reg, head.payload_byte);
            mod4_next = mod4_inc;
            if (head.last_byte)
            begin
                if (pad != 2'd0)
                begin
                    cnt_next   = {2'b00, pad};
                    state_next = ST_PAD;
                end
                else
                begin
                    cnt_next   = 4'd0;
                    state_next = ST_FCS;
                end
            end
            else
            begin
                item_pop   = 1'b1;
                state_next = ST_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            cnt_reg   <= '0;
            crc_reg   <= etf_pkg::CRC_INIT;
            mod4_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            mod4_reg  <= mod4_next;
        end
    end

endmodule

FILE: rtl/etf_outq.sv
// ----------------------------------------------------------------------------
// Ethernet TX framer output queue
// Holds built frame bytes until the consumer takes them.
// ----------------------------------------------------------------------------
module etf_outq #(
    parameter int DEPTH = etf_pkg::OUT_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  etf_pkg::oq_wr_t wr,
    output logic            ready,
    output logic            empty,
    input  logic            pop,
    output etf_pkg::out_t   head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    etf_pkg::out_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign ready  = (count_reg != CW'(DEPTH)) || do_pop;
    assign head   = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr.push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.data;
        end
    end

endmodule

FILE: rtl/ethernet_tx_framer_crc32.sv
// Payload into an idle block passes the input queue register, then the output queue register.
// Throughput: one frame byte per cycle when the output queue has room, set by the single-byte
// CRC update in the sequencer; a payload byte yields 1 byte, a first 15, a last 4-7 more (pad+FCS).
// Input queue depth IN_DEPTH, output queue depth OUT_DEPTH decouple the two sides.
// Reset (rst_n low, asynchronous): queues empty, CRC all ones, count zero, source MAC zero.
// ----------------------------------------------------------------------------
// Ethernet TX framer with CRC-32 FCS
// Builds header, payload, zero padding and FCS bytes from payload transfers.
// ----------------------------------------------------------------------------
`include "ethernet_tx_framer_crc32_assert.svh"

module ethernet_tx_framer_crc32 #(
    parameter int IN_DEPTH  = etf_pkg::IN_DEPTH,
    parameter int OUT_DEPTH = etf_pkg::OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // payload side
    input  logic        push,
    output logic        full,
    input  logic [47:0] dest_mac,
    input  logic [15:0] ethertype,
    input  logic [7:0]  payload_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    // frame side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_byte,
    output logic        frame_end,
    // configuration
    input  logic        source_mac_we,
    input  logic [47:0] source_mac_wdata
);

    logic [47:0]         source_mac_reg;
    etf_pkg::item_t      in_item;
    etf_pkg::item_t      head;
    logic                head_valid;
    logic                item_pop;
    logic                oq_ready;
    etf_pkg::oq_wr_t     oq_wr;
    etf_pkg::back_stat_t back_stat;
    etf_pkg::out_t       out_head;
    logic                oq_end_push;

    // source MAC register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mac_reg <= '0;
        end
        else if (source_mac_we)
        begin
            source_mac_reg <= source_mac_wdata;
        end
    end

    assign in_item = '{dest_mac:     dest_mac,
                       ethertype:    ethertype,
                       payload_byte: payload_byte,
                       first_byte:   first_byte,
                       last_byte:    last_byte};

    etf_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (in_item),
        .full       (full),
        .head       (head),
        .head_valid (head_valid),
        .pop        (item_pop)
    );

    etf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .item_pop   (item_pop),
        .source_mac (source_mac_reg),
        .oq_ready   (oq_ready),
        .oq_wr      (oq_wr),
        .stat       (back_stat)
    );

    etf_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (oq_wr),
        .ready (oq_ready),
        .empty (empty),
        .pop   (pop),
        .head  (out_head)
    );

    assign frame_byte = out_head.frame_byte;
    assign frame_end  = out_head.frame_end;

    // final FCS byte going into the output queue
    assign oq_end_push = oq_wr.push && oq_wr.data.frame_end;

    // internal checks
    `ETF_ASSERT_IMPL(a_oq_no_overflow, clk, rst_n, oq_wr.push, oq_ready)
    `ETF_ASSERT_IMPL(a_pop_needs_item, clk, rst_n, item_pop, head_valid)
    `ETF_ASSERT_NEXT(a_end_to_start, clk, rst_n, oq_end_push, back_stat.at_start)

endmodule

FILE: test/tb_ethernet_tx_framer_crc32.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ethernet TX framer testbench
// Sends payload bytes through the framer and checks every frame byte
// (header, payload, zero padding, FCS) against a predicted byte stream.
// Runs four stall profiles with a different source MAC in each.
// ----------------------------------------------------------------------------
module tb_ethernet_tx_framer_crc32;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_WAIT   = 20;

    // ------------------------------------------------------------------------
    // Predicted frame byte stream
    // ------------------------------------------------------------------------
    class tx_frame_model;
        localparam logic [31:0] POLY = 32'hEDB8_8320;
        localparam logic [31:0] SEED = 32'hFFFF_FFFF;

        logic [47:0]   source_mac;
        logic [31:0]   crc;
        logic [1:0]    byte_count;
        etf_pkg::out_t expected_frame[$];
        int            mismatches;
        int            checked;

        function new();
            source_mac = '0;
            crc        = SEED;
            byte_count = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // reflected CRC-32, one bit at a time
        function logic [31:0] crc32_shift_byte(logic [31:0] c, logic [7:0] b);
            logic fb;
            for (int k = 0; k < 8; k++)
            begin
                fb = c[0] ^ b[k];
                c  = c >> 1;
                if (fb)
                    c = c ^ POLY;
            end
            return c;
        endfunction

        function void add_byte(logic [7:0] b, logic e, bit in_crc);
            etf_pkg::out_t ob;
            ob.frame_byte = b;
            ob.frame_end  = e;
            expected_frame.push_back(ob);
            if (in_crc)
                crc = crc32_shift_byte(crc, b);
        endfunction

        // accepted payload transfer -> expected frame bytes
        function void note_payload(etf_pkg::item_t it);
            int          pad;
            logic [31:0] fcs;
            if (it.first_byte)
            begin
                crc        = SEED;
                byte_count = '0;
                for (int k = 5; k >= 0; k--)
                    add_byte(it.dest_mac[8*k +: 8], 1'b0, 1'b1);
                for (int k = 5; k >= 0; k--)
                    add_byte(source_mac[8*k +: 8], 1'b0, 1'b1);
                add_byte(it.ethertype[15:8], 1'b0, 1'b1);
                add_byte(it.ethertype[7:0], 1'b0, 1'b1);
            end
            add_byte(it.payload_byte, 1'b0, 1'b1);
            byte_count = byte_count + 2'd1;
            if (it.last_byte)
            begin
                pad = (4 - int'(byte_count)) % 4;
                fcs = ~crc;
                for (int k = 0; k < pad; k++)
                    add_byte(8'h00, 1'b0, 1'b0);
                for (int k = 0; k < 4; k++)
                    add_byte(fcs[8*k +: 8], k == 3, 1'b0);
                crc        = SEED;
                byte_count = '0;
            end
        endfunction

        // accepted frame byte vs oldest expectation
        function void check_frame_byte(logic [7:0] b, logic e);
            etf_pkg::out_t exp_b;
            if (expected_frame.size() == 0)
            begin
                $display("%0t: unexpected frame byte, expected none, actual %h end %b",
                         $time, b, e);
                mismatches++;
                return;
            end
            exp_b = expected_frame.pop_front();
            checked++;
            if (b !== exp_b.frame_byte)
            begin
                $display("%0t: frame_byte mismatch, expected %h, actual %h",
                         $time, exp_b.frame_byte, b);
                mismatches++;
            end
            if (e !== exp_b.frame_end)
            begin
                $display("%0t: frame_end mismatch, expected %b, actual %b",
                         $time, exp_b.frame_end, e);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_frame.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [47:0] dest_mac;
    logic [15:0] ethertype;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic        source_mac_we;
    logic [47:0] source_mac_wdata;

    tx_frame_model frame_model;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            cycles;
    int            transfers_sent;
    int            frames_started;
    int            mac_settings;

    ethernet_tx_framer_crc32 dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .dest_mac         (dest_mac),
        .ethertype        (ethertype),
        .payload_byte     (payload_byte),
        .first_byte       (first_byte),
        .last_byte        (last_byte),
        .empty            (empty),
        .pop              (pop),
        .frame_byte       (frame_byte),
        .frame_end        (frame_end),
        .source_mac_we    (source_mac_we),
        .source_mac_wdata (source_mac_wdata)
    );

    // clock
    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frame bytes still expected",
                     cycles, frame_model.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // frame side: check each transfer, then pick the next pop
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                frame_model.check_frame_byte(frame_byte, frame_end);
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Payload side tasks
    // ------------------------------------------------------------------------
    function automatic logic [47:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    task automatic send_payload(logic [47:0] d, logic [15:0] et, logic [7:0] pl,
                                logic f, logic l);
        etf_pkg::item_t it;
        it.dest_mac     = d;
        it.ethertype    = et;
        it.payload_byte = pl;
        it.first_byte   = f;
        it.last_byte    = l;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        dest_mac     <= d;
        ethertype    <= et;
        payload_byte <= pl;
        first_byte   <= f;
        last_byte    <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        frame_model.note_payload(it);
        transfers_sent++;
        if (f)
            frames_started++;
    endtask

    // random-content frame; close = 0 leaves it open
    task automatic send_frame(int len, bit close);
        for (int i = 0; i < len; i++)
            send_payload(rand_mac(), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), i == 0, close && (i == len - 1));
    endtask

    // stop sending and let every expected byte drain
    task automatic wait_drained();
        push <= 1'b0;
        while (frame_model.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_source_mac(logic [47:0] v);
        wait_drained();
        repeat (IDLE_WAIT) @(posedge clk);
        source_mac_we    <= 1'b1;
        source_mac_wdata <= v;
        @(posedge clk);
        source_mac_we    <= 1'b0;
        frame_model.source_mac = v;
        mac_settings++;
    endtask

    task automatic run_directed();
        // byte with no header before any frame, then close without header
        send_payload(48'h0, 16'h0, 8'h00, 1'b0, 1'b0);
        send_payload(rand_mac(), 16'h1234, 8'hFF, 1'b0, 1'b1);
        // one-byte frames at the field extremes
        send_payload(48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        send_payload(48'h0, 16'h0, 8'h00, 1'b1, 1'b1);
        // every padding amount
        for (int len = 2; len <= 5; len++)
            send_frame(len, 1'b1);
        // new header in mid-frame drops the frame in progress
        send_frame(3, 1'b0);
        send_frame(2, 1'b1);
    endtask

    // mostly well-formed frames, some stray bytes and cut frames
    task automatic run_random(int n_transfers);
        int target;
        int r;
        target = transfers_sent + n_transfers;
        while (transfers_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send_payload(rand_mac(), 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            else if (r < 20)
                send_frame($urandom_range(1, 4), 1'b0);
            else if (r < 90)
                send_frame($urandom_range(1, 8), 1'b1);
            else
                send_frame($urandom_range(9, 24), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        frame_model      = new();
        cycles           = 0;
        transfers_sent   = 0;
        frames_started   = 0;
        mac_settings     = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        rst_n            = 1'b0;
        push             = 1'b0;
        pop              = 1'b0;
        dest_mac         = '0;
        ethertype        = '0;
        payload_byte     = '0;
        first_byte       = 1'b0;
        last_byte        = 1'b0;
        source_mac_we    = 1'b0;
        source_mac_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full rate both sides
        write_source_mac(48'hFFFF_FFFF_FFFF);
        run_directed();
        run_random(20);

        // slow sender, with one full drain midway
        write_source_mac(48'h0);
        send_idle_pct = 77;
        run_random(15);
        wait_drained();
        run_random(15);

        // slow receiver
        write_source_mac(rand_mac());
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        run_random(30);

        // both sides idle now and then
        write_source_mac(48'hAAAA_5555_A5A5);
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        run_random(30);

        wait_drained();
        repeat (IDLE_WAIT) @(posedge clk);

        $display("Sent %0d payload transfers (%0d headers) under %0d source MAC settings",
                 transfers_sent, frames_started, mac_settings);
        $display("and four stall profiles; %0d frame bytes checked, %0d mismatches.",
                 frame_model.checked, frame_model.mismatches);
        if (frame_model.mismatches == 0 && frame_model.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
